// ===== rtl/core/hrtn_pkg.sv =====
// ---------------------------------------------------------------------------
// hrtn_pkg
// shared types and constants for the harris response / nms unit
// ---------------------------------------------------------------------------
package hrtn_pkg;

  localparam int unsigned RESP_W = 48;
  localparam int unsigned GRAD_W = 24;
  localparam int unsigned ROW_W  = 12;
  localparam int unsigned COL_W  = 10;
  localparam int unsigned HGT_W  = 13;
  localparam int unsigned KC_W   = 16;
  localparam int unsigned CFG_W  = 48;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned MAX_HEIGHT = 4096;

  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_K_COEFF      = 2'd2;
  localparam logic [IDX_W-1:0] REG_RESP_THRESH  = 2'd3;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  typedef struct packed {
    logic                     req_type;
    logic [GRAD_W-1:0]        grad_xx;
    logic [GRAD_W-1:0]        grad_yy;
    logic signed [GRAD_W-1:0] grad_xy;
    logic                     in_region;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]  pix_row;
    logic [COL_W-1:0]  pix_col;
    logic              is_keypoint;
    logic [RESP_W-1:0] strength;
    logic              frame_done;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_WRITE,
    ST_CHECK,
    ST_MID,
    ST_SCAN,
    ST_TAIL,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/core/harris_response_threshold_nms_unit.sv =====
// ---------------------------------------------------------------------------
// harris_response_threshold_nms_unit
// harris corner response, threshold and windowed non-maximum suppression
// ---------------------------------------------------------------------------
// a pixel's response is computed in the response pipeline and then stored in
//   the line store; a decision then scans the rows * cols of the clipped window,
//   one entry per cycle through the line store read port
// one transaction is handled at a time: a new one is taken only when idle
// reset: counters cleared, registers at 640 x 480, k 2621, threshold 1;
//   the line store needs no clearing since only written entries are read
module harris_response_threshold_nms_unit #(
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned WINDOW_HALF = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  hrtn_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output hrtn_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  logic [hrtn_pkg::IDX_W-1:0]  cfg_index,
  input  logic [hrtn_pkg::CFG_W-1:0]  cfg_data
);
  import hrtn_pkg::*;

  // ring of line buffers holds 2H+2 rows
  localparam int unsigned RING  = 2 * WINDOW_HALF + 2;
  localparam int unsigned RW    = $clog2(RING);
  localparam int unsigned DEPTH = RING * MAX_WIDTH;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned XW    = WW + 6;   // column math with window offset
  localparam int unsigned YW    = HGT_W + 1; // row math with window offset

  // configuration registers
  logic [WW-1:0]     frame_width;
  logic [HGT_W-1:0]  frame_height;
  logic [KC_W-1:0]   k_coeff;
  logic [RESP_W-1:0] resp_threshold;

  // frame position counters
  logic [ROW_W-1:0] in_row, out_row;
  logic [CW-1:0]    in_col, out_col;
  logic [RW-1:0]    in_ring, out_ring;
  logic             in_full;

  // fsm
  state_t state, state_next;

  // response unit
  logic              resp_start, resp_done;
  logic [RESP_W-1:0] resp;
  logic [RESP_W-1:0] resp_hold;

  // window scan
  logic [ROW_W-1:0] scan_row, scan_r1;
  logic [RW-1:0]    scan_ring;
  logic [CW-1:0]    scan_col, scan_c0, scan_c1;
  logic             scan_pend, scan_gt;
  logic [RESP_W-1:0] mid;
  logic              scan_row_end, scan_last;

  // memory ports
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [RESP_W-1:0] mem_rdata;

  // derived window bounds
  logic [YW-1:0] nr;
  logic [XW-1:0] nc;
  logic [ROW_W-1:0] r0;
  logic [CW-1:0]    c0;
  logic [RW-1:0]    back_rows, ring0;
  logic             win_ready, last_pix;

  logic [12:0] cfg_w_clamp;
  logic [13:0] cfg_h_clamp;

  // --- configuration, size writes restart the frame
  always_comb begin
    cfg_w_clamp = {2'b00, cfg_data[10:0]};
    if (cfg_w_clamp == 13'd0) begin
      cfg_w_clamp = 13'd1;
    end else if (cfg_w_clamp > 13'(MAX_WIDTH)) begin
      cfg_w_clamp = 13'(MAX_WIDTH);
    end
    cfg_h_clamp = {1'b0, cfg_data[12:0]};
    if (cfg_h_clamp == 14'd0) begin
      cfg_h_clamp = 14'd1;
    end else if (cfg_h_clamp > 14'(MAX_HEIGHT)) begin
      cfg_h_clamp = 14'(MAX_HEIGHT);
    end
  end

  logic size_write;
  assign size_write = cfg_we &&
    (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= WW'(640);
      frame_height   <= HGT_W'(480);
      k_coeff        <= KC_W'(2621);
      resp_threshold <= RESP_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width    <= WW'(cfg_w_clamp);
        REG_FRAME_HEIGHT: frame_height   <= cfg_h_clamp[HGT_W-1:0];
        REG_K_COEFF:      k_coeff        <= cfg_data[KC_W-1:0];
        REG_RESP_THRESH:  resp_threshold <= cfg_data[RESP_W-1:0];
        default: ;
      endcase
    end
  end

  // --- window bounds for the next pending decision
  always_comb begin
    nr = YW'(out_row) + YW'(WINDOW_HALF);
    if (nr >= YW'(frame_height)) begin
      nr = YW'(frame_height) - YW'(1);
    end
    nc = XW'(out_col) + XW'(WINDOW_HALF);
    if (nc >= XW'(frame_width)) begin
      nc = XW'(frame_width) - XW'(1);
    end
    r0 = (out_row > ROW_W'(WINDOW_HALF)) ? out_row - ROW_W'(WINDOW_HALF) : '0;
    c0 = (CW'(out_col) > CW'(WINDOW_HALF) && WINDOW_HALF < MAX_WIDTH)
         ? out_col - CW'(WINDOW_HALF) : '0;
    back_rows = RW'(out_row - r0);
    ring0 = (out_ring >= back_rows) ? out_ring - back_rows
                                    : RW'(RW'(RING) + out_ring - back_rows);
    win_ready = in_full || (nr < YW'(in_row)) ||
                (nr == YW'(in_row) && nc < XW'(in_col));
    last_pix = (YW'(out_row) + YW'(1) >= YW'(frame_height)) &&
               (XW'(out_col) + XW'(1) >= XW'(frame_width));
  end

  assign scan_row_end = (scan_col == scan_c1);
  assign scan_last    = scan_row_end && (scan_row == scan_r1);

  // --- next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.req_type == REQ_PIXEL && !in_full) begin
            state_next = ST_CALC;
          end else begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_CALC:  if (resp_done) state_next = ST_WRITE;
      ST_WRITE: state_next = ST_CHECK;
      ST_CHECK: state_next = win_ready ? ST_MID : ST_IDLE;
      ST_MID:   state_next = ST_SCAN;
      ST_SCAN:  if (scan_last) state_next = ST_TAIL;
      ST_TAIL:  state_next = ST_OUT;
      ST_OUT:   if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // --- fsm outputs
  always_comb begin
    in_ready   = 1'b0;
    resp_start = 1'b0;
    mem_we     = 1'b0;
    mem_raddr  = AW'(out_ring) * AW'(MAX_WIDTH) + AW'(out_col);
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        resp_start = in_valid && in_data.req_type == REQ_PIXEL && !in_full;
      end
      ST_WRITE: mem_we = 1'b1;
      ST_SCAN:  mem_raddr = AW'(scan_ring) * AW'(MAX_WIDTH) + AW'(scan_col);
      default: ;
    endcase
  end

  assign mem_waddr = AW'(in_ring) * AW'(MAX_WIDTH) + AW'(in_col);

  always_ff @(posedge clk) begin
    if (rst || size_write) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // --- frame counters
  always_ff @(posedge clk) begin
    if (rst || size_write) begin
      in_row   <= '0;
      in_col   <= '0;
      in_ring  <= '0;
      in_full  <= 1'b0;
      out_row  <= '0;
      out_col  <= '0;
      out_ring <= '0;
    end else begin
      // input side advances when a response lands in the line store
      if (state == ST_WRITE) begin
        if (XW'(in_col) + XW'(1) >= XW'(frame_width)) begin
          in_col <= '0;
          if (YW'(in_row) + YW'(1) >= YW'(frame_height)) begin
            in_row  <= '0;
            in_ring <= '0;
            in_full <= 1'b1;
          end else begin
            in_row  <= in_row + ROW_W'(1);
            in_ring <= (in_ring == RW'(RING - 1)) ? '0 : in_ring + RW'(1);
          end
        end else begin
          in_col <= in_col + CW'(1);
        end
      end
      // output side advances when a decision is loaded
      if (state == ST_OUT && (!out_valid || out_ready)) begin
        if (last_pix) begin
          in_row   <= '0;
          in_col   <= '0;
          in_ring  <= '0;
          in_full  <= 1'b0;
          out_row  <= '0;
          out_col  <= '0;
          out_ring <= '0;
        end else if (XW'(out_col) + XW'(1) >= XW'(frame_width)) begin
          out_col  <= '0;
          out_row  <= out_row + ROW_W'(1);
          out_ring <= (out_ring == RW'(RING - 1)) ? '0 : out_ring + RW'(1);
        end else begin
          out_col <= out_col + CW'(1);
        end
      end
    end
  end

  // --- response capture and window scan datapath
  always_ff @(posedge clk) begin
    if (resp_done) begin
      resp_hold <= resp;
    end
    if (state == ST_CHECK) begin
      scan_row  <= r0;
      scan_col  <= c0;
      scan_ring <= ring0;
      scan_r1   <= nr[ROW_W-1:0];
      scan_c0   <= c0;
      scan_c1   <= nc[CW-1:0];
    end
    if (state == ST_MID) begin
      // center read issued in the check cycle
      mid       <= mem_rdata;
      scan_pend <= 1'b0;
      scan_gt   <= 1'b0;
    end
    if (state == ST_SCAN) begin
      scan_pend <= 1'b1;
      if (scan_pend && mem_rdata > mid) begin
        scan_gt <= 1'b1;
      end
      if (scan_row_end) begin
        scan_col  <= scan_c0;
        scan_row  <= scan_row + ROW_W'(1);
        scan_ring <= (scan_ring == RW'(RING - 1)) ? '0 : scan_ring + RW'(1);
      end else begin
        scan_col <= scan_col + CW'(1);
      end
    end
    if (state == ST_TAIL && mem_rdata > mid) begin
      scan_gt <= 1'b1;
    end
  end

  // --- output register
  always_ff @(posedge clk) begin
    if (rst || size_write) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!out_valid || out_ready)) begin
      out_data.pix_row     <= out_row;
      out_data.pix_col     <= COL_W'(out_col);
      out_data.is_keypoint <= !scan_gt && (mid >= resp_threshold);
      out_data.strength    <= mid;
      out_data.frame_done  <= last_pix;
    end
  end

  hrtn_resp u_resp (
    .clk     (clk),
    .rst     (rst),
    .start   (resp_start),
    .item    (in_data),
    .k_coeff (k_coeff),
    .done    (resp_done),
    .resp    (resp)
  );

  hrtn_ram #(
    .WIDTH (RESP_W),
    .DEPTH (DEPTH)
  ) u_lines (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (resp_hold),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ===== rtl/core/hrtn_ram.sv =====
// ---------------------------------------------------------------------------
// hrtn_ram
// generic simple dual port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module hrtn_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/hrtn_resp.sv =====
// ---------------------------------------------------------------------------
// hrtn_resp
// four stage harris response pipeline: det - floor(k * trace^2 / 2^16)
// ---------------------------------------------------------------------------
module hrtn_resp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  hrtn_pkg::in_item_t               item,
  input  logic [hrtn_pkg::KC_W-1:0]        k_coeff,
  output logic                             done,
  output logic [hrtn_pkg::RESP_W-1:0]      resp
);
  import hrtn_pkg::*;

  logic [3:0] vld;

  // stage 1
  logic [47:0]        p_xx_yy;
  logic [46:0]        p_xy;
  logic [24:0]        trace;
  logic               region1;
  logic [KC_W-1:0]    k1;
  logic signed [47:0] xy_sq;
  // stage 2
  logic signed [48:0] det2;
  logic [49:0]        t2;
  logic               region2;
  logic [KC_W-1:0]    k2;
  // stage 3
  logic signed [48:0] det3;
  logic [49:0]        kt_hi;
  logic [31:0]        kt_lo;
  logic               region3;
  // stage 4
  logic [50:0]        kt;
  logic signed [51:0] r_full;

  assign xy_sq  = item.grad_xy * item.grad_xy;
  assign kt     = {1'b0, kt_hi} + {35'd0, kt_lo[31:16]};
  assign r_full = {{3{det3[48]}}, det3} - $signed({1'b0, kt});

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    p_xx_yy <= item.grad_xx * item.grad_yy;
    p_xy    <= xy_sq[46:0];
    trace   <= {1'b0, item.grad_xx} + {1'b0, item.grad_yy};
    region1 <= item.in_region;
    k1      <= k_coeff;

    det2    <= $signed({1'b0, p_xx_yy}) - $signed({2'b00, p_xy});
    t2      <= trace * trace;
    region2 <= region1;
    k2      <= k1;

    det3    <= det2;
    kt_hi   <= t2[49:16] * k2;
    kt_lo   <= t2[15:0] * k2;
    region3 <= region2;

    if (r_full < 0 || !region3) begin
      resp <= '0;
    end else begin
      resp <= r_full[RESP_W-1:0];
    end
  end

  assign done = vld[3];

endmodule

// ===== tb/tb_harris_response_threshold_nms_unit.sv =====
// ---------------------------------------------------------------------------
// tb_harris_response_threshold_nms_unit
// self-checking bench for the harris response / threshold / nms unit: small
// frames of raster pixels with random gradient products are streamed in, an
// internal line-store predictor works out every keypoint decision, and each
// output transaction is compared field by field in arrival order
// ---------------------------------------------------------------------------
module tb_harris_response_threshold_nms_unit;
  import hrtn_pkg::*;

  localparam int unsigned MAXW     = 1024;
  localparam int unsigned HALF_WIN = 10;
  localparam int unsigned RING     = 2 * HALF_WIN + 2;
  // worst decision: response math plus a full 21x21 window scan
  localparam int SETTLE     = 600;
  localparam int STALL_MAX  = 20000;
  localparam int HOLD_LEN   = 3000;
  localparam int ITEM_GOAL  = 1200;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  harris_response_threshold_nms_unit #(
    .MAX_WIDTH  (MAXW),
    .WINDOW_HALF(HALF_WIN)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  // -------------------------------------------------------------------------
  // predictor state: a private copy of the registers and of the line store
  // -------------------------------------------------------------------------
  int unsigned       frame_w, frame_h;
  longint unsigned   k_q16;
  logic [RESP_W-1:0] thresh;
  logic [RESP_W-1:0] resp_ring [RING*MAXW];
  int unsigned       wr_row, wr_col, rd_row, rd_col;
  bit                frame_in;   // every pixel of the frame has arrived

  out_item_t decisions_due[$];   // expected decisions, oldest first
  int        errors = 0;
  int        n_sent = 0;
  bit        idle_on = 1'b1;
  bit        hold_req = 1'b0;

  function automatic void restart_frame();
    wr_row = 0; wr_col = 0; rd_row = 0; rd_col = 0;
    frame_in = 1'b0;
  endfunction

  function automatic int unsigned ring_slot(int unsigned r, int unsigned c);
    return (r % RING) * MAXW + (c % MAXW);
  endfunction

  // cornerness: det - floor(k*trace^2 / 2^16), zero when negative or off-region
  function automatic logic [RESP_W-1:0] harris_resp(in_item_t p);
    longint unsigned a, b, tr, t2, kt;
    longint fxy, det, r;
    a = p.grad_xx;
    b = p.grad_yy;
    fxy = p.grad_xy;
    det = longint'(a * b) - fxy * fxy;
    tr = a + b;
    t2 = tr * tr;
    kt = (t2 >> 16) * k_q16 + (((t2 & 64'hFFFF) * k_q16) >> 16);
    r = det - longint'(kt);
    if (r < 0 || !p.in_region) return '0;
    return r[RESP_W-1:0];
  endfunction

  function automatic void cfg_apply(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    int unsigned x;
    case (idx)
      REG_FRAME_WIDTH: begin
        x = v[10:0];
        frame_w = (x < 1) ? 1 : (x > MAXW) ? MAXW : x;
        restart_frame();
      end
      REG_FRAME_HEIGHT: begin
        x = v[12:0];
        frame_h = (x < 1) ? 1 : (x > MAX_HEIGHT) ? MAX_HEIGHT : x;
        restart_frame();
      end
      REG_K_COEFF:     k_q16 = v[15:0];
      REG_RESP_THRESH: thresh = v[RESP_W-1:0];
      default: ;
    endcase
  endfunction

  // absorbs one input transaction; returns 1 with the decision it releases
  function automatic bit harris_decide(in_item_t p, output out_item_t d);
    int unsigned nr, nc, r0, c0, r, c;
    logic [RESP_W-1:0] mid;
    bit ready, is_max, last;
    d = '0;
    if (p.req_type == REQ_PIXEL && !frame_in) begin
      resp_ring[ring_slot(wr_row, wr_col)] = harris_resp(p);
      wr_col++;
      if (wr_col >= frame_w) begin
        wr_col = 0;
        wr_row++;
        if (wr_row >= frame_h) begin
          wr_row = 0;
          frame_in = 1'b1;
        end
      end
    end
    nr = (rd_row + HALF_WIN < frame_h - 1) ? rd_row + HALF_WIN : frame_h - 1;
    nc = (rd_col + HALF_WIN < frame_w - 1) ? rd_col + HALF_WIN : frame_w - 1;
    ready = frame_in || nr < wr_row || (nr == wr_row && nc < wr_col);
    if (!ready) return 1'b0;
    mid = resp_ring[ring_slot(rd_row, rd_col)];
    r0 = (rd_row > HALF_WIN) ? rd_row - HALF_WIN : 0;
    c0 = (rd_col > HALF_WIN) ? rd_col - HALF_WIN : 0;
    is_max = 1'b1;
    for (r = r0; r <= nr; r++)
      for (c = c0; c <= nc; c++)
        if (resp_ring[ring_slot(r, c)] > mid) is_max = 1'b0;
    last = (rd_row + 1 >= frame_h) && (rd_col + 1 >= frame_w);
    d.pix_row     = rd_row[ROW_W-1:0];
    d.pix_col     = rd_col[COL_W-1:0];
    d.is_keypoint = is_max && (mid >= thresh);
    d.strength    = mid;
    d.frame_done  = last;
    if (last) begin
      restart_frame();
    end else begin
      rd_col++;
      if (rd_col >= frame_w) begin
        rd_col = 0;
        rd_row++;
      end
    end
    return 1'b1;
  endfunction

  // -------------------------------------------------------------------------
  // checking: outputs first, then the input taken on the same edge
  // -------------------------------------------------------------------------
  task automatic report(string field, logic [47:0] got, logic [47:0] exp_v);
    $display("mismatch %s: got %0h, expected %0h", field, got, exp_v);
    errors++;
  endtask

  always @(posedge clk) begin
    out_item_t e;
    out_item_t d;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (decisions_due.size() == 0) begin
          report("unexpected transaction", out_data.strength, '0);
        end else begin
          e = decisions_due.pop_front();
          if (out_data.pix_row !== e.pix_row) report("pix_row", out_data.pix_row, e.pix_row);
          if (out_data.pix_col !== e.pix_col) report("pix_col", out_data.pix_col, e.pix_col);
          if (out_data.is_keypoint !== e.is_keypoint)
            report("is_keypoint", out_data.is_keypoint, e.is_keypoint);
          if (out_data.strength !== e.strength)
            report("strength", out_data.strength, e.strength);
          if (out_data.frame_done !== e.frame_done)
            report("frame_done", out_data.frame_done, e.frame_done);
        end
      end
      if (in_valid && in_ready)
        if (harris_decide(in_data, d)) decisions_due = {decisions_due, d};
    end
  end

  // watchdog: cycles in a row without any transaction
  int stall_cnt = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_MAX) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, plus a long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready = 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // drivers
  // -------------------------------------------------------------------------
  task automatic send_item(in_item_t p);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = p;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    n_sent++;
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (decisions_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    cfg_apply(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic in_item_t make_pixel(logic [23:0] a, logic [23:0] b,
                                          logic [23:0] xy, logic reg_bit);
    in_item_t p;
    p.req_type = REQ_PIXEL;
    p.grad_xx = a;
    p.grad_yy = b;
    p.grad_xy = xy;
    p.in_region = reg_bit;
    return p;
  endfunction

  function automatic in_item_t drain_item();
    in_item_t p;
    p = make_pixel(24'($urandom), 24'($urandom), 24'($urandom), 1'($urandom));
    p.req_type = REQ_DRAIN;
    return p;
  endfunction

  // mostly corner-like gradients so responses are positive and varied
  function automatic in_item_t rand_pixel();
    int m;
    logic reg_bit;
    m = $urandom_range(0, 9);
    reg_bit = ($urandom_range(0, 6) != 0);
    case (m)
      0, 1: return make_pixel(24'($urandom), 24'($urandom), 24'($urandom),
                              1'($urandom));
      8:    return make_pixel(24'd5000, 24'd5000, 24'd0, reg_bit);  // ties
      9:    return make_pixel(24'($urandom_range(24'hF00000, 24'hFFFFFF)),
                              24'($urandom_range(24'hF00000, 24'hFFFFFF)),
                              24'($urandom_range(0, 4000) - 2000), reg_bit);
      default:
        return make_pixel(24'($urandom_range(0, 20000)),
                          24'($urandom_range(0, 20000)),
                          24'($urandom_range(0, 2000) - 1000), reg_bit);
    endcase
  endfunction

  task automatic set_frame(int unsigned w, int unsigned h);
    cfg_write(REG_FRAME_WIDTH, w);
    cfg_write(REG_FRAME_HEIGHT, h);
  endtask

  // streams a frame with optional stray drains, then flushes it out
  task automatic stream_frame(bit noise);
    int unsigned total;
    total = frame_w * frame_h;
    for (int unsigned i = 0; i < total; i++) begin
      if (noise && $urandom_range(0, 9) == 0) send_item(drain_item());
      send_item(rand_pixel());
    end
    // a pixel after the frame end stands in for a drain
    while (frame_in)
      send_item(($urandom_range(0, 3) == 0) ? rand_pixel() : drain_item());
  endtask

  // -------------------------------------------------------------------------
  // tests
  // -------------------------------------------------------------------------
  task automatic test_directed();
    set_frame(4, 3);
    cfg_write(REG_K_COEFF, 2621);
    cfg_write(REG_RESP_THRESH, 1);
    send_item(drain_item());                                 // nothing ready
    send_item(make_pixel(24'hFFFFFF, 24'hFFFFFF, 24'h800000, 1'b1));
    send_item(make_pixel(24'hFFFFFF, 24'hFFFFFF, 24'h7FFFFF, 1'b1));
    send_item(make_pixel(24'hFFFFFF, 24'hFFFFFF, 24'h000000, 1'b1));
    send_item(make_pixel(24'h000000, 24'h000000, 24'h000000, 1'b1));
    send_item(drain_item());                                 // before frame end
    send_item(make_pixel(24'hFFFFFF, 24'hFFFFFF, 24'h000000, 1'b0));  // off region
    send_item(make_pixel(24'hFFFFFF, 24'h000000, 24'h000000, 1'b1));  // negative
    // k and threshold change mid-frame while quiet
    wait_idle();
    cfg_write(REG_K_COEFF, 0);
    cfg_write(REG_RESP_THRESH, 0);
    for (int i = 0; i < 6; i++) send_item(rand_pixel());
    send_item(rand_pixel());                                 // past the frame end
    while (frame_in) send_item(drain_item());
    send_item(drain_item());
    wait_idle();
  endtask

  task automatic test_register_clamps();
    set_frame(0, 0);                                         // both clamp to 1
    cfg_write(REG_K_COEFF, 16'hFFFF);
    cfg_write(REG_RESP_THRESH, 48'hFFFF_FFFF_FFFF);
    send_item(rand_pixel());
    send_item(rand_pixel());
    wait_idle();
    set_frame(2047, 2);                                      // width to 1024
    for (int i = 0; i < 40; i++) send_item(rand_pixel());
    wait_idle();
    set_frame(1, 8191);                                      // height to 4096
    cfg_write(REG_RESP_THRESH, 0);
    for (int i = 0; i < 60; i++) send_item(rand_pixel());
    wait_idle();
    set_frame(1024, 1);
    cfg_write(REG_K_COEFF, 2621);
    for (int i = 0; i < 30; i++) send_item(rand_pixel());
    wait_idle();
  endtask

  task automatic random_settings();
    logic [CFG_W-1:0] t;
    case ($urandom_range(0, 3))
      0: cfg_write(REG_K_COEFF, 0);
      1: cfg_write(REG_K_COEFF, 16'hFFFF);
      default: cfg_write(REG_K_COEFF, $urandom_range(0, 6000));
    endcase
    case ($urandom_range(0, 4))
      0: t = 0;
      1: t = 48'hFFFF_FFFF_FFFF;
      2: t = CFG_W'({$urandom, $urandom});
      default: t = $urandom_range(1, 200000000);
    endcase
    cfg_write(REG_RESP_THRESH, t);
    set_frame($urandom_range(1, 16), $urandom_range(1, 12));
  endtask

  task automatic test_random_frames(int goal);
    int unsigned n;
    while (n_sent < goal) begin
      random_settings();
      if ($urandom_range(0, 6) == 0) begin
        // broken frame: cut short, the next size write restarts it
        n = $urandom_range(0, frame_w * frame_h - 1);
        for (int unsigned i = 0; i < n; i++) send_item(rand_pixel());
      end else begin
        stream_frame(1'b1);
      end
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    cfg_write(REG_RESP_THRESH, 1);
    set_frame(16, 12);
    hold_req = 1'b1;                                         // receiver holds off
    stream_frame(1'b0);
    // sender pause until every decision is back
    in_valid = 1'b0;
    while (decisions_due.size() != 0) @(posedge clk);
    @(negedge clk);
    wait_idle();
  endtask

  task automatic test_no_idling();
    idle_on = 1'b0;
    repeat (2) begin
      random_settings();
      stream_frame(1'b0);
      wait_idle();
    end
  endtask

  initial begin
    cfg_apply(REG_FRAME_WIDTH, 640);
    cfg_apply(REG_FRAME_HEIGHT, 480);
    cfg_apply(REG_K_COEFF, 2621);
    cfg_apply(REG_RESP_THRESH, 1);
    repeat (10) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_register_clamps();
    test_backpressure();
    test_random_frames(ITEM_GOAL - 300);
    test_no_idling();
    if (decisions_due.size() != 0) begin
      $display("%0d decisions never arrived", decisions_due.size());
      errors++;
    end
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
